// File: rtl/joystick_menu_navigator_assert.svh
// Assertion macros for the joystick menu navigator.
// Needs a clock named clk and a synchronous reset named rst in the including scope.
`ifndef JOYSTICK_MENU_NAVIGATOR_ASSERT_SVH
`define JOYSTICK_MENU_NAVIGATOR_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define JMN_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("jmn assertion failed");

// Next-cycle implication, checked outside reset.
`define JMN_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("jmn assertion failed");

`endif

// File: rtl/jmn_pkg.sv
// Shared types and constants for the joystick menu navigator.
// No dependencies.
package jmn_pkg;

  localparam int unsigned SEL_W   = 5;
  localparam int unsigned COUNT_W = 6;
  localparam int unsigned AXIS_W  = 8;
  // hard ceiling on the list length, set by the 5-bit index
  localparam int unsigned LIST_CEIL = 32;

  localparam logic signed [AXIS_W-1:0] AXIS_UP_LIMIT   = -8'sd64;
  localparam logic signed [AXIS_W-1:0] AXIS_DOWN_LIMIT = 8'sd64;

  typedef struct packed {
    logic [SEL_W-1:0] selected_index;
    logic [SEL_W-1:0] window_top;
    logic             more_above;
    logic             more_below;
    logic             launch;
    logic             moved;
  } result_t;

endpackage

// File: rtl/joystick_menu_navigator.sv
// Joystick menu navigator: selection and scroll window control, one poll per transaction.
// The input passes through the stage register, then the result register, before the result is valid.
// Throughput: one poll per cycle while out_ready holds; while a result waits the stage register takes one more poll.
// Reset (rst, synchronous) clears item count, previous axis/button, selection and window top.
// Depends on jmn_pkg and joystick_menu_navigator_assert.svh.
module joystick_menu_navigator #(
  parameter int unsigned WINDOW_ROWS = 8,
  parameter int unsigned MAX_ITEMS   = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [jmn_pkg::COUNT_W-1:0]       item_count,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [jmn_pkg::AXIS_W-1:0] axis_y,
  input  logic                              button_one,
  input  logic                              read_error,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [jmn_pkg::SEL_W-1:0]         selected_index,
  output logic [jmn_pkg::SEL_W-1:0]         window_top,
  output logic                              more_above,
  output logic                              more_below,
  output logic                              launch,
  output logic                              moved
);

  localparam int unsigned LIMIT =
    (MAX_ITEMS < jmn_pkg::LIST_CEIL) ? MAX_ITEMS : jmn_pkg::LIST_CEIL;
  localparam logic [jmn_pkg::COUNT_W-1:0] LIMIT_C = jmn_pkg::COUNT_W'(LIMIT);
  localparam logic signed [8:0] VR_S = 9'(WINDOW_ROWS);

  // configuration
  logic [jmn_pkg::COUNT_W-1:0] list_count;

  // input stage
  logic                              stg_valid;
  logic signed [jmn_pkg::AXIS_W-1:0] stg_axis;
  logic                              stg_button;
  logic                              stg_error;

  // navigation state
  logic signed [jmn_pkg::AXIS_W-1:0] prev_axis;
  logic                              prev_button;
  logic [jmn_pkg::SEL_W-1:0]         selection;
  logic [jmn_pkg::SEL_W-1:0]         top_row;

  jmn_pkg::result_t res;
  jmn_pkg::result_t res_next;

  logic [jmn_pkg::SEL_W-1:0] selection_next;
  logic [jmn_pkg::SEL_W-1:0] top_row_next;

  logic                          advance;
  logic                          process;
  logic [jmn_pkg::COUNT_W-1:0]   n_eff;
  logic                          go_up;
  logic                          go_down;
  logic                          do_up;
  logic                          do_down;
  logic                          press;

  // window fit arithmetic
  logic signed [8:0] sel_s;
  logic signed [8:0] top_s;
  logic signed [8:0] n_s;
  logic signed [8:0] cap0;
  logic signed [8:0] last0;
  logic signed [8:0] lo;
  logic signed [8:0] t1;
  logic signed [8:0] t2;
  logic signed [8:0] tn;
  logic signed [8:0] edge_row;
  logic signed [8:0] out_top_s;
  logic signed [8:0] out_cap;
  logic              td0;
  logic              bd0;
  logic              out_td;

  assign cfg_ready = 1'b1;
  assign advance   = !out_valid || out_ready;
  assign process   = stg_valid && advance;
  assign in_ready  = !stg_valid || advance;

  assign n_eff = (list_count > LIMIT_C) ? LIMIT_C : list_count;

  always_comb begin
    go_up   = (stg_axis < jmn_pkg::AXIS_UP_LIMIT) && !(prev_axis < jmn_pkg::AXIS_UP_LIMIT);
    go_down = (stg_axis > jmn_pkg::AXIS_DOWN_LIMIT)
              && !(prev_axis > jmn_pkg::AXIS_DOWN_LIMIT);
    press   = stg_button && !prev_button;
    do_up   = !stg_error && go_up && (selection != '0);
    do_down = !stg_error && go_down
              && ((jmn_pkg::COUNT_W'(selection) + 6'd1) < n_eff);

    selection_next = selection;
    if (do_up) begin
      selection_next = selection - 5'd1;
    end else if (do_down) begin
      selection_next = selection + 5'd1;
    end

    // Smallest top at or after the current one whose window holds the selection, or the
    // selection itself if it lies above; the last shown row rises monotonically with the top.
    sel_s = $signed({4'b0000, selection_next});
    top_s = $signed({4'b0000, top_row});
    n_s   = $signed({3'b000, n_eff});
    td0   = (top_row != '0);
    cap0  = VR_S - $signed({8'b0, td0});
    bd0   = (top_s + cap0) < n_s;
    last0 = top_s + cap0 - $signed({8'b0, bd0}) - 9'sd1;
    lo    = top_s + 9'sd1;
    edge_row = n_s - VR_S + 9'sd1;

    // bottom ellipsis still present at the candidate top
    t2 = sel_s - VR_S + 9'sd3;
    if (t2 < lo) t2 = lo;
    // bottom ellipsis gone at the candidate top
    t1 = sel_s - VR_S + 9'sd2;
    if (t1 < edge_row) t1 = edge_row;
    if (t1 < lo) t1 = lo;

    if (sel_s <= last0) begin
      tn = top_s;
    end else if (t2 < edge_row) begin
      tn = t2;
    end else begin
      tn = t1;
    end
    if (sel_s < tn) tn = sel_s;

    top_row_next = (do_up || do_down) ? tn[jmn_pkg::SEL_W-1:0] : top_row;

    out_top_s = $signed({4'b0000, top_row_next});
    out_td    = (top_row_next != '0);
    out_cap   = VR_S - $signed({8'b0, out_td});

    res_next.selected_index = selection_next;
    res_next.window_top     = top_row_next;
    res_next.more_above     = (n_eff != '0) && out_td;
    res_next.more_below     = (n_eff != '0) && ((out_top_s + out_cap) < n_s);
    res_next.launch         = !stg_error && press && (n_eff != '0);
    res_next.moved          = do_up || do_down;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      list_count  <= '0;
      stg_valid   <= 1'b0;
      out_valid   <= 1'b0;
      prev_axis   <= '0;
      prev_button <= 1'b0;
      selection   <= '0;
      top_row     <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        list_count <= item_count;
      end
      if (in_ready) begin
        stg_valid <= in_valid;
      end
      if (advance) begin
        out_valid <= stg_valid;
      end
      if (process) begin
        if (stg_error) begin
          prev_axis   <= '0;
          prev_button <= 1'b0;
        end else begin
          prev_axis   <= stg_axis;
          prev_button <= stg_button;
        end
        selection <= selection_next;
        top_row   <= top_row_next;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stg_axis   <= axis_y;
      stg_button <= button_one;
      stg_error  <= read_error;
    end
    if (process) begin
      res <= res_next;
    end
  end

  assign selected_index = res.selected_index;
  assign window_top     = res.window_top;
  assign more_above     = res.more_above;
  assign more_below     = res.more_below;
  assign launch         = res.launch;
  assign moved          = res.moved;

`include "joystick_menu_navigator_assert.svh"

  // the window never starts below the highlighted entry
  `JMN_ASSERT_IMP(a_top_not_past_sel, out_valid, window_top <= selected_index)
  `JMN_ASSERT_IMP(a_no_above_at_zero, out_valid && (window_top == '0), !more_above)
  `JMN_ASSERT_IMP(a_no_launch_empty, process && (n_eff == '0), !res_next.launch)
  // a stalled result with a full stage holds the input side off
  `JMN_ASSERT_NXT(a_stall_holds, stg_valid && out_valid && !out_ready, stg_valid && out_valid)

endmodule
